// ===== design/ledcf_pkg.sv =====
// ----------------------------------------------------------------------------
// ledcf_pkg
// Shared types, register codes, constants and the gamma 2.8 table for the
// LED color fade sequencer.
// ----------------------------------------------------------------------------
package ledcf_pkg;

  localparam int MAX_COLORS_DEF    = 4;
  localparam int MAX_PHASE_LEN_DEF = 50;

  localparam int DIV_W     = 16;  // dividend width, also the position width
  localparam int COLOR_W   = 24;
  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_0     = 3'd0,
    REG_COLOR_1     = 3'd1,
    REG_COLOR_2     = 3'd2,
    REG_COLOR_3     = 3'd3,
    REG_COLOR_COUNT = 3'd4,
    REG_HOLD_LEN    = 3'd5,
    REG_FADE_LENS   = 3'd6,
    REG_DARK_LEN    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_DIVP,
    S_LEVEL,
    S_MUL,
    S_DONE
  } seq_state_t;

  // saturated fade lengths, as seen by the sequencer
  typedef struct packed {
    logic [LEN_W-1:0] fade_in;
    logic [LEN_W-1:0] fade_out;
  } fade_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [7:0] GAMMA [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
    8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
    8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,
    8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,8'd16,8'd16,
    8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,
    8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,8'd24,8'd25,
    8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,
    8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,8'd35,8'd36,
    8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,
    8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd50,
    8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,
    8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,8'd67,8'd68,
    8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,
    8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,8'd87,8'd89,
    8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,
    8'd102,8'd104,8'd105,8'd107,8'd109,8'd110,8'd112,8'd114,
    8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,
    8'd129,8'd131,8'd133,8'd135,8'd137,8'd138,8'd140,8'd142,
    8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,
    8'd160,8'd162,8'd164,8'd167,8'd169,8'd171,8'd173,8'd175,
    8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,
    8'd196,8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd213,
    8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,
    8'd236,8'd239,8'd241,8'd244,8'd247,8'd249,8'd252,8'd255
  };

  // reset color of palette entry i; entries without a register stay black
  function automatic logic [COLOR_W-1:0] color_reset(input int i);
    logic [COLOR_W-1:0] c;
    case (i)
      0:       c = 24'hFF0000;
      1:       c = 24'h00FF00;
      2:       c = 24'h0000FF;
      3:       c = 24'hFFFFFF;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/ledcf_div.sv =====
// ----------------------------------------------------------------------------
// ledcf_div
// Shared restoring divider: one quotient bit per cycle, quotient and
// remainder held after the done pulse until the next start.
// ----------------------------------------------------------------------------
module ledcf_div import ledcf_pkg::*; #(
  parameter int DVSR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  input  logic [DVSR_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [DIV_W-1:0]  quot,
  output logic [DVSR_W-1:0] rem
);

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  quot_r, quot_nxt;
  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, quot_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign fits  = trial >= {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract where the divisor fits
      quot_nxt = {quot_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;
  assign rem       = rem_r;

  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done at once");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvsr_r))
    else $error("divider remainder not below divisor");

endmodule

// ===== design/ledcf_cfg.sv =====
// ----------------------------------------------------------------------------
// ledcf_cfg
// Configuration registers with saturation of the lengths and color count,
// and the derived period, pattern length and phase boundaries.
// ----------------------------------------------------------------------------
module ledcf_cfg import ledcf_pkg::*; #(
  parameter int MAX_COLORS    = MAX_COLORS_DEF,
  parameter int MAX_PHASE_LEN = MAX_PHASE_LEN_DEF,
  parameter int PER_W         = $clog2(4 * MAX_PHASE_LEN + 1),
  parameter int TOT_W         = $clog2(4 * MAX_PHASE_LEN * MAX_COLORS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [COLOR_W-1:0]                    cfg_wdata,
  output logic [MAX_COLORS-1:0][COLOR_W-1:0]    palette,
  output fade_cfg_t                             fade,
  output logic [PER_W-1:0]                      per,
  output logic [TOT_W-1:0]                      total,
  output logic [PER_W-1:0]                      bound_hold,
  output logic [PER_W-1:0]                      bound_out
);

  localparam int CNT_W = $clog2(MAX_COLORS + 1);

  logic [2:0]       count_r;
  logic [LEN_W-1:0] hold_r, fin_r, fout_r, dark_r;
  logic [LEN_W-1:0] hold_s, fin_s, fout_s, dark_s;
  logic [CNT_W-1:0] count_s;

  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_pal
    logic [COLOR_W-1:0] color_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        color_r <= color_reset(i);
      end else if (cfg_we && (i < 4) && (cfg_index == CFG_IDX_W'(i))) begin
        color_r <= cfg_wdata;
      end
    end
    assign palette[i] = color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd2;
      hold_r  <= LEN_W'(1);
      fin_r   <= '0;
      fout_r  <= '0;
      dark_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_COUNT: count_r <= cfg_wdata[2:0];
        REG_HOLD_LEN:    hold_r  <= cfg_wdata[LEN_W-1:0];
        REG_FADE_LENS: begin
          // bits 7:6 carry nothing
          fin_r  <= cfg_wdata[5:0];
          fout_r <= cfg_wdata[13:8];
        end
        REG_DARK_LEN:    dark_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fin_s  = (fin_r  > LEN_W'(MAX_PHASE_LEN)) ? LEN_W'(MAX_PHASE_LEN) : fin_r;
    fout_s = (fout_r > LEN_W'(MAX_PHASE_LEN)) ? LEN_W'(MAX_PHASE_LEN) : fout_r;
    dark_s = (dark_r > LEN_W'(MAX_PHASE_LEN)) ? LEN_W'(MAX_PHASE_LEN) : dark_r;
    if (hold_r > LEN_W'(MAX_PHASE_LEN)) begin
      hold_s = LEN_W'(MAX_PHASE_LEN);
    end else if (hold_r == '0) begin
      hold_s = LEN_W'(1);
    end else begin
      hold_s = hold_r;
    end
    if (count_r < 3'd2) begin
      count_s = CNT_W'(2);
    end else if (32'(count_r) > MAX_COLORS) begin
      count_s = CNT_W'(MAX_COLORS);
    end else begin
      count_s = CNT_W'(count_r);
    end
  end

  assign fade.fade_in  = fin_s;
  assign fade.fade_out = fout_s;
  assign bound_hold    = PER_W'(fin_s) + PER_W'(hold_s);
  assign bound_out     = bound_hold + PER_W'(fout_s);
  assign per           = bound_out + PER_W'(dark_s);
  assign total         = TOT_W'(per) * TOT_W'(count_s);

endmodule

// ===== design/led_color_fade_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_color_fade_sequencer_top
// Looping gamma-corrected color fade: each tick gives the next RGB color,
// a set command loads the position modulo the pattern length.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_cmd, in_position
//  out     | output    | out_valid/out_stall| out_pixel_color
//  cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
//  A set command runs the 16-step shared divider once (position modulo); a
//  tick in hold or dark runs it twice (also split into palette entry and
//  offset) and a tick in a fade three times (also the fade level). A fade
//  tick then scales the red, green and blue channels in turn.
//  in_stall stays high from acceptance until a tick's result is in the output
//  register or a set command has loaded the position; a result waits there
//  under out_stall while the next item runs. Synchronous active-low reset;
//  there is no clearing pass.
module led_color_fade_sequencer_top import ledcf_pkg::*; #(
  parameter int MAX_COLORS    = MAX_COLORS_DEF,
  parameter int MAX_PHASE_LEN = MAX_PHASE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [DIV_W-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COLOR_W-1:0]   out_pixel_color,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  localparam int PER_W = $clog2(4 * MAX_PHASE_LEN + 1);
  localparam int TOT_W = $clog2(4 * MAX_PHASE_LEN * MAX_COLORS + 1);
  localparam int IDX_W = $clog2(MAX_COLORS);

  logic [MAX_COLORS-1:0][COLOR_W-1:0] palette;
  fade_cfg_t          fade;
  logic [PER_W-1:0]   per, bound_hold, bound_out;
  logic [TOT_W-1:0]   total;

  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [TOT_W-1:0]   div_dvsr;
  logic [DIV_W-1:0]   div_quot;
  logic [TOT_W-1:0]   div_rem;

  seq_state_t         state_r, state_nxt;
  logic               cmd_r, cmd_nxt;
  logic [TOT_W-1:0]   seq_pos_r, seq_pos_nxt;
  logic [COLOR_W-1:0] rgb_r, rgb_nxt;
  logic [7:0]         gamma_r, gamma_nxt;
  logic [1:0]         ch_r, ch_nxt;
  logic [COLOR_W-1:0] pix_r, pix_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_pix_r, out_pix_nxt;

  logic               in_accept;
  logic [PER_W-1:0]   off;
  logic [DIV_W-1:0]   lvl_x, lvl_num;
  logic [7:0]         chan;
  logic [15:0]        prod;
  logic [16:0]        scaled;
  logic [COLOR_W-1:0] pal_sel;

  ledcf_cfg #(
    .MAX_COLORS    (MAX_COLORS),
    .MAX_PHASE_LEN (MAX_PHASE_LEN),
    .PER_W         (PER_W),
    .TOT_W         (TOT_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .palette    (palette),
    .fade       (fade),
    .per        (per),
    .total      (total),
    .bound_hold (bound_hold),
    .bound_out  (bound_out)
  );

  ledcf_div #(
    .DVSR_W (TOT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (div_dvsr),
    .stat    (div_stat),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign off     = div_rem[PER_W-1:0];
  assign pal_sel = palette[div_quot[IDX_W-1:0]];

  // fade level numerator 255*x, x = k+1 on the way in, G-j on the way out
  assign lvl_x   = (off < bound_hold) ? (DIV_W'(off) + 1'b1) : DIV_W'(bound_out - off);
  assign lvl_num = (lvl_x << 8) - lvl_x;

  // channel * gamma / 255, exact for products below 65535
  always_comb begin
    case (ch_r)
      2'd0:    chan = rgb_r[23:16];
      2'd1:    chan = rgb_r[15:8];
      default: chan = rgb_r[7:0];
    endcase
  end
  assign prod   = 16'(chan) * 16'(gamma_r);
  assign scaled = 17'(prod) + 17'(prod[15:8]) + 17'd1;

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    seq_pos_nxt      = seq_pos_r;
    rgb_nxt          = rgb_r;
    gamma_nxt        = gamma_r;
    ch_nxt           = ch_r;
    pix_nxt          = pix_r;
    out_pix_nxt      = out_pix_r;
    out_valid_nxt    = out_valid_r && out_stall;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(seq_pos_r);
    div_dvsr         = total;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt       = in_cmd;
          div_req.start = 1'b1;
          if (in_cmd == CMD_SET) begin
            div_req.dividend = in_position;
          end
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          if (cmd_r == CMD_SET) begin
            seq_pos_nxt = div_rem;
            state_nxt   = S_IDLE;
          end else begin
            // advance past the position being shown
            seq_pos_nxt      = div_rem + 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(div_rem);
            div_dvsr         = TOT_W'(per);
            state_nxt        = S_DIVP;
          end
        end
      end
      S_DIVP: begin
        if (div_stat.done) begin
          rgb_nxt = pal_sel;
          if (off < PER_W'(fade.fade_in)) begin
            div_req.start    = 1'b1;
            div_req.dividend = lvl_num;
            div_dvsr         = TOT_W'(fade.fade_in) + 1'b1;
            state_nxt        = S_LEVEL;
          end else if (off < bound_hold) begin
            pix_nxt   = pal_sel;
            state_nxt = S_DONE;
          end else if (off < bound_out) begin
            div_req.start    = 1'b1;
            div_req.dividend = lvl_num;
            div_dvsr         = TOT_W'(fade.fade_out) + 1'b1;
            state_nxt        = S_LEVEL;
          end else begin
            pix_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_LEVEL: begin
        if (div_stat.done) begin
          gamma_nxt = GAMMA[div_quot[7:0]];
          ch_nxt    = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // red first, shift each scaled byte in from the right
        pix_nxt = {pix_r[15:0], scaled[15:8]};
        ch_nxt  = ch_r + 1'b1;
        if (ch_r == 2'd2) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = pix_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seq_pos_r   <= '0;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      seq_pos_r   <= seq_pos_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
    end
    cmd_r     <= cmd_nxt;
    rgb_r     <= rgb_nxt;
    gamma_r   <= gamma_nxt;
    pix_r     <= pix_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_pix_r;

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEVEL && div_stat.done) |-> (div_quot[DIV_W-1:8] == '0))
    else $error("fade level above 255");

  a_mul_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (ch_r != 2'd3))
    else $error("channel counter out of range");

endmodule
